@@ hdl/sbd_pkg.sv @@
// Package for the stop-bit ASCII string decoder.
// Holds the word types, phase and status codes and the queue depth.
// No dependencies.
package sbd_pkg;

    // Byte values with a fixed meaning in the stream
    localparam logic [7:0] LAST_MARK = 8'h80;
    localparam logic [7:0] CHAR_MASK = 8'h7F;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Reset value of the character limit register
    localparam logic [6:0] MAX_CHARS_RST = 7'd64;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_STRING = 2'd1,
        PH_ZERO   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_END      = 3'd4
    } t_status;

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
        logic       field_optional;
    } t_in;

    // Result word
    typedef struct packed {
        logic [6:0] char_value;
        logic       char_valid;
        logic       field_done;
        logic [2:0] status;
    } t_out;

    // One classified byte: one or two results
    typedef struct packed {
        logic two;
        t_out r0;
        t_out r1;
    } t_job;

endpackage

@@ hdl/sbd_fifo.sv @@
// Short flip-flop queue between the front and the back of the decoder.
// Generic over word width and depth; no package dependency.
module sbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt,  n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Fill level stays within depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue fill level beyond depth");

    // Pointers agree with the fill level when empty
    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wptr == r_rptr))
        else $error("empty queue with unequal pointers");

endmodule

@@ hdl/sbd_front.sv @@
// Front of the decoder: takes each byte, tracks the field phase and count,
// and turns the byte into a job of zero, one or two result words.
// Depends on sbd_pkg.
module sbd_front #(
    parameter int MAX_LEN = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  sbd_pkg::t_in  i_item,
    input  logic [6:0]    i_max_chars,
    output logic          o_job_valid,
    output sbd_pkg::t_job o_job
);
    localparam int LB = $clog2(MAX_LEN + 1);
    localparam int LW = (LB > 7) ? LB : 7;

    sbd_pkg::t_phase r_phase, n_phase;
    logic [LW-1:0]   r_count, n_count;

    logic [LW-1:0]   m_ext, lim, cnt_in;
    sbd_pkg::t_out   sb_res, res0, res1;
    sbd_pkg::t_phase sb_phase;
    logic [LW-1:0]   sb_count;
    logic [1:0]      nres;
    logic [7:0]      b;

    assign b     = i_item.data_byte;
    assign m_ext = LW'(i_max_chars);

    // Clamp the limit to one .. MAX_LEN
    always_comb begin
        if (m_ext == '0) begin
            lim = LW'(1);
        end else if (m_ext > LW'(MAX_LEN)) begin
            lim = LW'(MAX_LEN);
        end else begin
            lim = m_ext;
        end
    end

    // Decode one character byte inside a string
    always_comb begin
        unique case (r_phase)
            sbd_pkg::PH_ZERO:   cnt_in = LW'(1);
            sbd_pkg::PH_STRING: cnt_in = r_count;
            default:            cnt_in = '0;
        endcase
        sb_res = '0;
        if (cnt_in >= lim) begin
            sb_res.field_done = 1'b1;
            sb_res.status     = sbd_pkg::ST_OVERFLOW;
            sb_phase          = sbd_pkg::PH_IDLE;
            sb_count          = '0;
        end else if (b[7]) begin
            sb_res.char_value = b[6:0];
            sb_res.char_valid = 1'b1;
            sb_res.field_done = 1'b1;
            sb_res.status     = sbd_pkg::ST_OK;
            sb_phase          = sbd_pkg::PH_IDLE;
            sb_count          = '0;
        end else begin
            sb_res.char_value = b[6:0];
            sb_res.char_valid = 1'b1;
            sb_phase          = sbd_pkg::PH_STRING;
            sb_count          = cnt_in + LW'(1);
        end
    end

    // Next phase and the job for the accepted byte
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        res0    = '0;
        res1    = '0;
        nres    = 2'd0;
        if (i_item.end_of_data) begin
            res0.field_done = 1'b1;
            res0.status     = sbd_pkg::ST_END;
            nres            = 2'd1;
            n_phase         = sbd_pkg::PH_IDLE;
            n_count         = '0;
        end else begin
            unique case (r_phase)
                sbd_pkg::PH_ZERO: begin
                    if (b == sbd_pkg::LAST_MARK) begin
                        n_phase = sbd_pkg::PH_IDLE;
                        n_count = '0;
                        if (lim < LW'(2)) begin
                            res0.field_done = 1'b1;
                            res0.status     = sbd_pkg::ST_OVERFLOW;
                            nres            = 2'd1;
                        end else begin
                            res0.char_valid = 1'b1;
                            res1.char_valid = 1'b1;
                            res1.field_done = 1'b1;
                            res1.status     = sbd_pkg::ST_EMPTY;
                            nres            = 2'd2;
                        end
                    end else begin
                        // Leading zero becomes the first character
                        res0.char_valid = 1'b1;
                        res1    = sb_res;
                        nres    = 2'd2;
                        n_phase = sb_phase;
                        n_count = sb_count;
                    end
                end
                sbd_pkg::PH_STRING: begin
                    res0    = sb_res;
                    nres    = 2'd1;
                    n_phase = sb_phase;
                    n_count = sb_count;
                end
                default: begin
                    if (i_item.field_optional && b == sbd_pkg::LAST_MARK) begin
                        res0.field_done = 1'b1;
                        res0.status     = sbd_pkg::ST_NULL;
                        nres            = 2'd1;
                        n_count         = '0;
                    end else if (i_item.field_optional && b == sbd_pkg::ZERO_BYTE) begin
                        n_phase = sbd_pkg::PH_ZERO;
                        n_count = '0;
                    end else begin
                        res0    = sb_res;
                        nres    = 2'd1;
                        n_phase = sb_phase;
                        n_count = sb_count;
                    end
                end
            endcase
        end
    end

    assign o_job_valid = i_accept && (nres != 2'd0);
    assign o_job.two   = (nres == 2'd2);
    assign o_job.r0    = res0;
    assign o_job.r1    = res1;

    // Hold state until a byte is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sbd_pkg::PH_IDLE;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Idle and pending-zero phases carry no count
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sbd_pkg::PH_IDLE || r_phase == sbd_pkg::PH_ZERO)
        |-> (r_count == '0))
        else $error("count set outside a string");

    // End of data always closes the field
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.end_of_data) |=> (r_phase == sbd_pkg::PH_IDLE))
        else $error("field left open after end of data");

    // A string phase always holds at least one character
    a_string_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sbd_pkg::PH_STRING) |-> (r_count != '0))
        else $error("string phase with no characters");

endmodule

@@ hdl/sbd_back.sv @@
// Back of the decoder: pops jobs from the queue and hands out their
// result words one at a time. Depends on sbd_pkg.
module sbd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sbd_pkg::t_job i_job,
    input  logic          i_job_empty,
    output logic          o_job_pop,
    output sbd_pkg::t_out o_result,
    output logic          o_empty,
    input  logic          i_pop
);
    logic r_sel, n_sel;
    logic take;

    assign o_empty  = i_job_empty;
    assign o_result = r_sel ? i_job.r1 : i_job.r0;
    assign take     = i_pop && !i_job_empty;

    // Advance to the second word or drop the job
    always_comb begin
        n_sel     = r_sel;
        o_job_pop = 1'b0;
        if (take) begin
            if (i_job.two && !r_sel) begin
                n_sel = 1'b1;
            end else begin
                n_sel     = 1'b0;
                o_job_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= n_sel;
        end
    end

    // Second word selected only on a held two-word job
    a_sel_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (!i_job_empty && i_job.two))
        else $error("second word selected without a two-word job");

    // A taken first word of a two-word job keeps the job
    a_keep_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_job.two && !r_sel) |-> !o_job_pop)
        else $error("two-word job dropped after its first word");

endmodule

@@ hdl/stop_bit_ascii_string_decoder.sv @@
// Top level of the stop-bit ASCII string decoder.
// Instantiates sbd_front, sbd_fifo and sbd_back; depends on sbd_pkg.
//
//  channel  | handshake               | word
//  ---------+-------------------------+-----------------------------------
//  input    | push / full             | i_item   (data_byte, end, optional)
//  result   | empty / pop             | o_result (char, valid, done, status)
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_data (max_chars)
//
// One byte is accepted per cycle while full is low; its results enter a
// four-job queue at the same edge and reach the result port after the jobs
// ahead. The result port gives one word per cycle while pop is high and
// empty is low, so a byte with two words needs two pops; full rises when
// the job queue is full. Reset is synchronous; there is no clearing pass.
module stop_bit_ascii_string_decoder #(
    parameter int MAX_LEN = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sbd_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output sbd_pkg::t_out o_result,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [6:0]    i_cfg_data
);
    localparam int JW = $bits(sbd_pkg::t_job);

    logic          r_max_chars;
    logic [6:0]    r_max;
    logic          accept;
    logic          job_valid;
    sbd_pkg::t_job job_in, job_out;
    logic [JW-1:0] job_out_bits;
    logic          job_empty, job_pop;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign job_out     = sbd_pkg::t_job'(job_out_bits);

    // Hold the character limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= sbd_pkg::MAX_CHARS_RST;
            r_max_chars <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max       <= i_cfg_data;
            r_max_chars <= 1'b1;
        end
    end

    sbd_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_max_chars (r_max),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    sbd_fifo #(
        .WIDTH (JW),
        .DEPTH (sbd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_out_bits),
        .o_empty (job_empty)
    );

    sbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    // A default limit is in force until the first write
    a_cfg_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_max_chars |-> (r_max == sbd_pkg::MAX_CHARS_RST))
        else $error("limit changed without a configuration write");

    // No result shown when the queue is empty
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty == job_empty)
        else $error("result port empty flag out of step with queue");

    // A full queue accepts no byte
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !accept)
        else $error("byte accepted while queue full");

endmodule
